FILE: sv/spct_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spct_pkg
// Shared types and constants of the sector page cache tag controller.
// ----------------------------------------------------------------------------
package spct_pkg;

    // field widths
    localparam int LBA_W      = 48;
    localparam int CNT_W      = 16;
    localparam int WAY_OUT_W  = 7;
    localparam int OFF_W      = 4;
    localparam int CHUNK_W    = 5;
    localparam int INV_W      = 8;
    localparam int CFG_ADDR_W = 1;

    // page geometry: 16 sectors per page, tag holds the page number
    localparam int PAGE_SECTORS = 16;
    localparam int PAGE_SHIFT   = 4;
    localparam int TAG_W        = LBA_W - PAGE_SHIFT;

    localparam int DEFAULT_ENTRIES = 128;
    localparam logic [CNT_W-1:0] MAX_XFER_RESET = 16'd256;

    typedef enum logic [1:0] {
        CMD_LOOKUP = 2'd0,
        CMD_FILL   = 2'd1,
        CMD_INVAL  = 2'd2,
        CMD_NOP    = 2'd3
    } t_cmd;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_CAPACITY = 1'b0,
        CFG_MAX_XFER = 1'b1
    } t_cfg_reg;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } t_state;

    // outcome of comparing one stored entry against the request
    typedef struct packed {
        logic hit;      // valid and same page
        logic overlap;  // valid and inside the written range
    } t_match;

endpackage

FILE: sv/spct_match.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spct_match
// Shared compare unit: checks one stored tag against the request page and
// against the written sector range.
// ----------------------------------------------------------------------------
module spct_match
    import spct_pkg::*;
(
    input  logic [TAG_W-1:0] i_req_page,  // page number of the request lba
    input  logic [LBA_W:0]   i_req_end,   // lba + count, one past the range
    input  logic [TAG_W-1:0] i_tag,
    input  logic             i_tag_vld,
    output t_match           o_match
);

    logic [LBA_W:0] tag_start;

    assign tag_start = {1'b0, i_tag, {PAGE_SHIFT{1'b0}}};

    // lba < tag_start + page size  <=>  lba page <= tag page
    always_comb begin
        o_match.hit     = i_tag_vld && (i_tag == i_req_page);
        o_match.overlap = i_tag_vld && (i_req_page <= i_tag) && (i_req_end > tag_start);
    end

endmodule

FILE: sv/sector_page_cache_tags.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sector_page_cache_tags
// Tag controller of a fully associative page cache with round-robin
// replacement: lookup, fill completion and write invalidation.
// ----------------------------------------------------------------------------
// A command is taken when i_start is high and o_busy is low. Fill-done,
// no-op and zero-count commands skip the scan and go straight to the done
// step, from which the o_done strobe is registered. Lookups and invalidates
// walk the tag memory one entry per cycle through a single compare unit, and
// the memory read is registered; a lookup stops at the lowest entry that
// hits, while a miss or an invalidate walks all ENTRIES entries. Results are
// shown for exactly one cycle on o_done and cannot be held off; o_busy drops
// in that same cycle, so the next command may be issued alongside it. Tags
// are not reset: an entry can match only after a fill has written it.
// ----------------------------------------------------------------------------
module sector_page_cache_tags
    import spct_pkg::*;
#(
    parameter int ENTRIES = DEFAULT_ENTRIES
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // command
    input  logic                  i_start,
    output logic                  o_busy,
    input  logic [1:0]            i_cmd,
    input  logic [LBA_W-1:0]      i_lba,
    input  logic [CNT_W-1:0]      i_count,
    input  logic [WAY_OUT_W-1:0]  i_fill_way,
    input  logic                  i_fill_ok,
    // configuration
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [LBA_W-1:0]      i_cfg_data,
    // result
    output logic                  o_done,
    output logic                  o_hit,
    output logic [WAY_OUT_W-1:0]  o_way,
    output logic [OFF_W-1:0]      o_page_offset,
    output logic [CHUNK_W-1:0]    o_hit_chunk,
    output logic [CHUNK_W-1:0]    o_fill_sectors,
    output logic [CNT_W-1:0]      o_direct_chunk,
    output logic [INV_W-1:0]      o_invalidated
);

    localparam int WAY_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int ICNT_W = $clog2(ENTRIES + 1);
    localparam logic [WAY_W-1:0] LAST_WAY = WAY_W'(ENTRIES - 1);

    // configuration registers
    logic [LBA_W-1:0] r_capacity;
    logic [CNT_W-1:0] r_max_xfer;

    // sequencer and request
    t_state              r_state, n_state;
    t_cmd                r_cmd;
    logic [LBA_W-1:0]    r_lba;
    logic [CNT_W-1:0]    r_count;
    logic [LBA_W:0]      r_end;
    logic [WAY_OUT_W-1:0] r_fill_way;

    // tag store and scan pipeline
    logic [TAG_W-1:0]    r_tag_mem [ENTRIES];
    logic [ENTRIES-1:0]  r_valid;
    logic [WAY_W-1:0]    r_victim;
    logic [WAY_W-1:0]    r_addr;
    logic                r_issue_end;
    logic                r_rd_live;
    logic [WAY_W-1:0]    r_rd_idx;
    logic                r_rd_vld;
    logic [TAG_W-1:0]    r_rd_tag;
    logic                r_found;
    logic [WAY_W-1:0]    r_found_idx;
    logic [ICNT_W-1:0]   r_inv_cnt;

    // result registers
    logic                r_done;
    logic                r_hit;
    logic [WAY_OUT_W-1:0] r_way;
    logic [OFF_W-1:0]    r_off;
    logic [CHUNK_W-1:0]  r_chunk;
    logic [CHUNK_W-1:0]  r_fill;
    logic [CNT_W-1:0]    r_direct;
    logic [INV_W-1:0]    r_inv;

    logic                accept;
    logic                scan_cmd;
    logic                fill_write;
    logic                issue;
    t_match              match;
    logic                lookup_hit;
    logic                scan_clear;
    logic                miss;

    assign accept   = i_start && (r_state == S_IDLE);
    assign scan_cmd = (i_count != '0)
                   && (t_cmd'(i_cmd) == CMD_LOOKUP || t_cmd'(i_cmd) == CMD_INVAL);
    assign fill_write = accept && (t_cmd'(i_cmd) == CMD_FILL) && i_fill_ok
                     && ({{(32-WAY_OUT_W){1'b0}}, i_fill_way} < 32'(ENTRIES));
    assign issue    = (r_state == S_SCAN) && !r_issue_end;

    // compare unit, shared by every entry of the scan
    spct_match u_match (
        .i_req_page (r_lba[LBA_W-1:PAGE_SHIFT]),
        .i_req_end  (r_end),
        .i_tag      (r_rd_tag),
        .i_tag_vld  (r_rd_vld),
        .o_match    (match)
    );

    assign lookup_hit = (r_state == S_SCAN) && r_rd_live && (r_cmd == CMD_LOOKUP) && match.hit;
    assign scan_clear = (r_state == S_SCAN) && r_rd_live && (r_cmd == CMD_INVAL) && match.overlap;
    assign miss       = (r_state == S_DONE) && (r_cmd == CMD_LOOKUP) && (r_count != '0)
                     && !r_found;

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) n_state = scan_cmd ? S_SCAN : S_DONE;
            end
            S_SCAN: begin
                if (lookup_hit || (r_rd_live && r_rd_idx == LAST_WAY)) n_state = S_DONE;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= '0;
            r_max_xfer <= MAX_XFER_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_addr))
                CFG_CAPACITY: r_capacity <= i_cfg_data;
                CFG_MAX_XFER: r_max_xfer <= i_cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // request capture
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd      <= t_cmd'(i_cmd);
            r_lba      <= i_lba;
            r_count    <= i_count;
            r_end      <= {1'b0, i_lba} + {{(LBA_W+1-CNT_W){1'b0}}, i_count};
            r_fill_way <= i_fill_way;
        end
    end

    // tag memory: written by fill done, read once per scan cycle
    always_ff @(posedge i_clk) begin
        if (fill_write) begin
            r_tag_mem[WAY_W'(i_fill_way)] <= i_lba[LBA_W-1:PAGE_SHIFT];
        end
        if (issue) begin
            r_rd_tag <= r_tag_mem[r_addr];
        end
    end

    // scan address and read stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issue_end <= 1'b0;
            r_rd_live   <= 1'b0;
            r_addr      <= '0;
        end else if (accept) begin
            r_issue_end <= 1'b0;
            r_rd_live   <= 1'b0;
            r_addr      <= '0;
        end else begin
            r_rd_live <= issue;
            if (issue) begin
                r_rd_idx <= r_addr;
                r_rd_vld <= r_valid[r_addr];
                r_addr   <= r_addr + 1'b1;
                if (r_addr == LAST_WAY) r_issue_end <= 1'b1;
            end
        end
    end

    // scan outcome
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found   <= 1'b0;
            r_inv_cnt <= '0;
        end else if (accept) begin
            r_found   <= 1'b0;
            r_inv_cnt <= '0;
        end else begin
            if (lookup_hit) begin
                r_found     <= 1'b1;
                r_found_idx <= r_rd_idx;
            end
            if (scan_clear) r_inv_cnt <= r_inv_cnt + 1'b1;
        end
    end

    // valid bits and round-robin victim
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_victim <= '0;
        end else begin
            if (fill_write) r_valid[WAY_W'(i_fill_way)] <= 1'b1;
            if (scan_clear) r_valid[r_rd_idx] <= 1'b0;
            if (miss) begin
                r_valid[r_victim] <= 1'b0;
                r_victim <= (r_victim == LAST_WAY) ? '0 : r_victim + 1'b1;
            end
        end
    end

    // result formatting
    logic [CHUNK_W-1:0] page_rem;
    logic [LBA_W-1:0]   page_start;
    logic [LBA_W-1:0]   cap_left;

    assign page_rem   = CHUNK_W'(PAGE_SECTORS) - {1'b0, r_lba[OFF_W-1:0]};
    assign page_start = {r_lba[LBA_W-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
    assign cap_left   = r_capacity - page_start;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= (r_state == S_DONE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE) begin
            r_hit    <= 1'b0;
            r_way    <= '0;
            r_off    <= '0;
            r_chunk  <= '0;
            r_fill   <= '0;
            r_direct <= '0;
            r_inv    <= '0;
            case (r_cmd)
                CMD_LOOKUP: begin
                    if (r_count != '0) begin
                        r_off    <= r_lba[OFF_W-1:0];
                        r_direct <= (r_count < r_max_xfer) ? r_count : r_max_xfer;
                        if (r_found) begin
                            r_hit   <= 1'b1;
                            r_way   <= WAY_OUT_W'(r_found_idx);
                            r_chunk <= (r_count < {{(CNT_W-CHUNK_W){1'b0}}, page_rem})
                                     ? r_count[CHUNK_W-1:0] : page_rem;
                        end else begin
                            r_way <= WAY_OUT_W'(r_victim);
                            if (page_start < r_capacity) begin
                                r_fill <= (cap_left < LBA_W'(PAGE_SECTORS))
                                        ? cap_left[CHUNK_W-1:0] : CHUNK_W'(PAGE_SECTORS);
                            end
                        end
                    end
                end
                CMD_FILL:  r_way <= r_fill_way;
                CMD_INVAL: r_inv <= INV_W'(r_inv_cnt);
                default: ;
            endcase
        end
    end

    assign o_busy         = (r_state != S_IDLE);
    assign o_done         = r_done;
    assign o_hit          = r_hit;
    assign o_way          = r_way;
    assign o_page_offset  = r_off;
    assign o_hit_chunk    = r_chunk;
    assign o_fill_sectors = r_fill;
    assign o_direct_chunk = r_direct;
    assign o_invalidated  = r_inv;

    // checks
    a_done_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |=> o_done)
        else $error("result strobe missing after done step");

    a_hit_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_hit) |-> (o_fill_sectors == '0 && o_invalidated == '0))
        else $error("hit result carries miss or invalidate fields");

    a_fill_no_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && t_cmd'(i_cmd) == CMD_FILL) |=> (r_state == S_DONE))
        else $error("fill done entered a scan");

    a_victim_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        miss |=> (r_victim != $past(r_victim)))
        else $error("victim pointer did not advance on a miss");

    a_scan_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> !o_done)
        else $error("result strobe during a scan");

endmodule

FILE: verif/tb_sector_page_cache_tags.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sector_page_cache_tags
// Self-checking testbench for the sector page cache tag controller.
// ----------------------------------------------------------------------------
// Commands go in one at a time through the start/busy handshake. A scoreboard
// keeps its own copy of the tags, valid bits, victim pointer and both
// registers. It works out each result when the command transfer happens and
// checks every o_done strobe against the oldest outstanding result. A directed
// pass covers the corner cases first. Random phases follow: mostly
// lookup / fill-done pairs over a small working set of pages, so that hits,
// evictions and overlapping invalidates all come up, plus noise commands.
// Each phase runs under its own capacity and max-transfer setting.
// ----------------------------------------------------------------------------
module tb_sector_page_cache_tags;
    import spct_pkg::*;

    localparam int NUM_WAYS     = DEFAULT_ENTRIES;
    localparam int RAND_ITEMS   = 1950;
    localparam int PHASES       = 6;
    localparam int POOL_PAGES   = 48;
    localparam int DRAIN_CYCLES = NUM_WAYS + 8;
    localparam int MAX_PRINTS   = 100;
    localparam logic [LBA_W-1:0] LBA_MAX = '1;

    // one result, in port order
    typedef struct packed {
        logic                 hit;
        logic [WAY_OUT_W-1:0] way;
        logic [OFF_W-1:0]     page_offset;
        logic [CHUNK_W-1:0]   hit_chunk;
        logic [CHUNK_W-1:0]   fill_sectors;
        logic [CNT_W-1:0]     direct_chunk;
        logic [INV_W-1:0]     invalidated;
    } t_tag_result;

    // ------------------------------------------------------------------------
    // Scoreboard: tag store copy, register copy, outstanding results
    // ------------------------------------------------------------------------
    class tag_scoreboard;
        logic [LBA_W-1:0]     page_tag [NUM_WAYS];
        bit                   page_valid [NUM_WAYS];
        logic [WAY_OUT_W-1:0] victim;
        logic [LBA_W-1:0]     capacity;
        logic [CNT_W-1:0]     max_xfer;
        t_tag_result          pending [$];
        int                   errors;

        function new();
            int i;
            for (i = 0; i < NUM_WAYS; i++) begin
                page_tag[i]   = '0;
                page_valid[i] = 1'b0;
            end
            victim   = '0;
            capacity = '0;
            max_xfer = MAX_XFER_RESET;
            errors   = 0;
        endfunction

        function void set_reg(t_cfg_reg idx, logic [LBA_W-1:0] value);
            if (idx == CFG_CAPACITY)
                capacity = value;
            else
                max_xfer = value[CNT_W-1:0];
        endfunction

        // apply one accepted command to the tag store, queue its result
        function t_tag_result note_command(t_cmd cmd, logic [LBA_W-1:0] lba,
                                           logic [CNT_W-1:0] cnt,
                                           logic [WAY_OUT_W-1:0] fway, logic fok);
            t_tag_result      r;
            logic [LBA_W-1:0] page;
            logic [63:0]      room;
            logic [63:0]      range_lo;
            logic [63:0]      range_end;
            int               hit_way;
            int               i;
            r    = '0;
            page = {lba[LBA_W-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
            case (cmd)
                CMD_LOOKUP: begin
                    if (cnt != 0) begin
                        // scan downward so the lowest matching entry wins
                        hit_way = -1;
                        for (i = NUM_WAYS - 1; i >= 0; i--)
                            if (page_valid[i] && page_tag[i] == page)
                                hit_way = i;
                        r.page_offset  = lba[OFF_W-1:0];
                        r.direct_chunk = (cnt < max_xfer) ? cnt : max_xfer;
                        if (hit_way >= 0) begin
                            r.hit       = 1'b1;
                            r.way       = WAY_OUT_W'(hit_way);
                            room        = 64'(PAGE_SECTORS) - 64'(lba[OFF_W-1:0]);
                            r.hit_chunk = (64'(cnt) < room) ? cnt[CHUNK_W-1:0]
                                                            : room[CHUNK_W-1:0];
                        end else begin
                            r.way              = victim;
                            page_valid[victim] = 1'b0;
                            victim = WAY_OUT_W'((int'(victim) + 1) % NUM_WAYS);
                            // page at or past capacity: fill of zero, go direct
                            if (page < capacity) begin
                                room = 64'(capacity - page);
                                r.fill_sectors = (room < PAGE_SECTORS)
                                               ? room[CHUNK_W-1:0]
                                               : CHUNK_W'(PAGE_SECTORS);
                            end
                        end
                    end
                end
                CMD_FILL: begin
                    r.way = fway;
                    if (int'(fway) < NUM_WAYS && fok) begin
                        page_tag[fway]   = page;
                        page_valid[fway] = 1'b1;
                    end
                end
                CMD_INVAL: begin
                    // overlap test in 64 bits so a range past the top does not wrap
                    range_lo  = 64'(lba);
                    range_end = 64'(lba) + 64'(cnt);
                    if (cnt != 0)
                        for (i = 0; i < NUM_WAYS; i++)
                            if (page_valid[i] &&
                                range_lo < 64'(page_tag[i]) + PAGE_SECTORS &&
                                range_end > 64'(page_tag[i])) begin
                                page_valid[i]  = 1'b0;
                                r.invalidated  = r.invalidated + 1'b1;
                            end
                end
                default: ;
            endcase
            pending.push_back(r);
            return r;
        endfunction

        task report(string msg);
            errors++;
            if (errors <= MAX_PRINTS)
                $display("[%0t] mismatch: %s", $time, msg);
        endtask

        task compare_field(string name, logic [CNT_W-1:0] got, logic [CNT_W-1:0] want);
            if (got !== want)
                report($sformatf("%s got %0h want %0h", name, got, want));
        endtask

        task check_result(t_tag_result got);
            t_tag_result want;
            if (pending.size() == 0) begin
                report($sformatf("result with nothing outstanding, way %0d", got.way));
                return;
            end
            want = pending.pop_front();
            compare_field("hit",          CNT_W'(got.hit),          CNT_W'(want.hit));
            compare_field("way",          CNT_W'(got.way),          CNT_W'(want.way));
            compare_field("page_offset",  CNT_W'(got.page_offset),  CNT_W'(want.page_offset));
            compare_field("hit_chunk",    CNT_W'(got.hit_chunk),    CNT_W'(want.hit_chunk));
            compare_field("fill_sectors", CNT_W'(got.fill_sectors), CNT_W'(want.fill_sectors));
            compare_field("direct_chunk", got.direct_chunk,         want.direct_chunk);
            compare_field("invalidated",  CNT_W'(got.invalidated),  CNT_W'(want.invalidated));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // DUT signals and instance
    // ------------------------------------------------------------------------
    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_start    = 1'b0;
    logic [1:0]            i_cmd      = CMD_NOP;
    logic [LBA_W-1:0]      i_lba      = '0;
    logic [CNT_W-1:0]      i_count    = '0;
    logic [WAY_OUT_W-1:0]  i_fill_way = '0;
    logic                  i_fill_ok  = 1'b0;
    logic                  i_cfg_we   = 1'b0;
    t_cfg_reg              i_cfg_addr = CFG_CAPACITY;
    logic [LBA_W-1:0]      i_cfg_data = '0;
    logic                  o_busy;
    logic                  o_done;
    logic                  o_hit;
    logic [WAY_OUT_W-1:0]  o_way;
    logic [OFF_W-1:0]      o_page_offset;
    logic [CHUNK_W-1:0]    o_hit_chunk;
    logic [CHUNK_W-1:0]    o_fill_sectors;
    logic [CNT_W-1:0]      o_direct_chunk;
    logic [INV_W-1:0]      o_invalidated;

    sector_page_cache_tags u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .o_busy         (o_busy),
        .i_cmd          (i_cmd),
        .i_lba          (i_lba),
        .i_count        (i_count),
        .i_fill_way     (i_fill_way),
        .i_fill_ok      (i_fill_ok),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_data     (i_cfg_data),
        .o_done         (o_done),
        .o_hit          (o_hit),
        .o_way          (o_way),
        .o_page_offset  (o_page_offset),
        .o_hit_chunk    (o_hit_chunk),
        .o_fill_sectors (o_fill_sectors),
        .o_direct_chunk (o_direct_chunk),
        .o_invalidated  (o_invalidated)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    tag_scoreboard        sb;
    t_tag_result          last_result;
    logic [LBA_W-1:0]     pool_page [POOL_PAGES];
    bit                   idle_on;
    int                   stretch_left = 0;
    int                   items_sent   = 0;

    // result monitor: the strobe lasts one cycle and cannot be stalled
    always @(posedge i_clk) begin
        if (i_rst_n && o_done)
            sb.check_result({o_hit, o_way, o_page_offset, o_hit_chunk,
                             o_fill_sectors, o_direct_chunk, o_invalidated});
    end

    function automatic logic [LBA_W-1:0] rand48();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[LBA_W-1:0];
    endfunction

    function automatic logic [WAY_OUT_W-1:0] rand_way();
        return WAY_OUT_W'($urandom_range(0, (1 << WAY_OUT_W) - 1));
    endfunction

    // mostly short requests, some long, a few at the extremes
    function automatic logic [CNT_W-1:0] pick_count();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return CNT_W'($urandom_range(1, 40));
            6, 7:             return CNT_W'($urandom_range(1, 65535));
            8:                return '1;
            default:          return '0;
        endcase
    endfunction

    // one command transfer; the sender gap runs in stretches, on or off
    task automatic issue(t_cmd cmd, logic [LBA_W-1:0] lba, logic [CNT_W-1:0] cnt,
                         logic [WAY_OUT_W-1:0] fway, logic fok);
        int gap;
        if (stretch_left == 0) begin
            idle_on      = ($urandom_range(0, 3) != 0);
            stretch_left = $urandom_range(10, 40);
        end
        stretch_left--;
        gap = idle_on ? $urandom_range(0, 15) : 0;
        if (gap != 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start    <= 1'b1;
        i_cmd      <= cmd;
        i_lba      <= lba;
        i_count    <= cnt;
        i_fill_way <= fway;
        i_fill_ok  <= fok;
        do @(posedge i_clk); while (o_busy);
        last_result = sb.note_command(cmd, lba, cnt, fway, fok);
        items_sent++;
    endtask

    // mostly well-formed pair: lookup, then on a miss report the fill, mostly of the chosen victim
    task automatic lookup_and_fill(logic [LBA_W-1:0] lba, logic [CNT_W-1:0] cnt);
        logic [WAY_OUT_W-1:0] fway;
        issue(CMD_LOOKUP, lba, cnt, rand_way(), 1'($urandom_range(0, 1)));
        if (!last_result.hit && cnt != 0) begin
            fway = ($urandom_range(0, 9) == 0) ? rand_way() : last_result.way;
            issue(CMD_FILL, {lba[LBA_W-1:PAGE_SHIFT], 4'($urandom_range(0, 15))},
                  CNT_W'($urandom), fway, ($urandom_range(0, 9) != 0));
        end
    endtask

    // stop issuing and let every outstanding result come back
    task automatic drain();
        i_start <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_reg idx, logic [LBA_W-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_reg(idx, value);
        @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        int               ph;
        int               i;
        int               pick;
        int               target;
        logic [LBA_W-1:0] base;
        logic [LBA_W-1:0] a;
        logic [LBA_W-1:0] cap;
        logic [CNT_W-1:0] cnt;
        logic [CNT_W-1:0] mx;

        sb = new();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset settings, capacity 0 so every miss goes direct
        issue(CMD_LOOKUP, 48'h0, '0, '0, 1'b0);            // zero count: no search
        issue(CMD_NOP, LBA_MAX, '1, '1, 1'b1);             // unused command
        issue(CMD_LOOKUP, 48'h15, 16'd40, '0, 1'b0);       // miss, victim 0
        issue(CMD_FILL, 48'h15, '0, 7'd0, 1'b1);
        issue(CMD_LOOKUP, 48'h1F, '1, '0, 1'b0);           // hit, last sector of page
        issue(CMD_FILL, 48'h203, '0, 7'd9, 1'b1);          // same page in two entries
        issue(CMD_FILL, 48'h200, '0, 7'd4, 1'b1);
        issue(CMD_FILL, 48'h2000, '0, 7'd6, 1'b0);         // failed read
        issue(CMD_LOOKUP, 48'h20A, 16'd3, '0, 1'b0);       // lowest duplicate wins
        issue(CMD_LOOKUP, 48'h2000, 16'd16, '0, 1'b0);     // still a miss
        issue(CMD_FILL, LBA_MAX, '0, 7'd127, 1'b1);        // top page, last entry
        issue(CMD_LOOKUP, LBA_MAX, 16'd1, '0, 1'b0);       // hit on the last entry
        issue(CMD_INVAL, 48'h0, 16'h10, '0, 1'b0);         // ends just below a page
        issue(CMD_INVAL, 48'h1F, '0, '0, 1'b0);            // zero count clears nothing
        issue(CMD_INVAL, LBA_MAX, '1, '0, 1'b0);           // range runs past the top
        issue(CMD_INVAL, 48'h1F, 16'd1, '0, 1'b0);
        issue(CMD_INVAL, 48'h100, 16'h101, '0, 1'b0);      // both duplicates go
        issue(CMD_LOOKUP, rand48(), 16'd1, '0, 1'b0);
        drain();

        // capacity ends inside a page, smallest direct transfer
        write_reg(CFG_CAPACITY, 48'h25);
        write_reg(CFG_MAX_XFER, 48'd1);
        issue(CMD_LOOKUP, 48'h7, 16'd7, '0, 1'b0);         // full page fill
        issue(CMD_LOOKUP, 48'h2F, 16'd2, '0, 1'b0);        // clipped fill
        issue(CMD_LOOKUP, 48'h30, 16'd9, '0, 1'b0);        // page past capacity
        drain();

        // largest capacity, zero max transfer
        write_reg(CFG_CAPACITY, LBA_MAX);
        write_reg(CFG_MAX_XFER, '0);
        issue(CMD_LOOKUP, 48'hFFFF_FFFF_FFF3, 16'd20, '0, 1'b0);
        issue(CMD_LOOKUP, 48'h0, '1, '0, 1'b0);
        drain();
        write_reg(CFG_MAX_XFER, 48'hFFFF);
        issue(CMD_LOOKUP, 48'h5, '1, '0, 1'b0);

        // random phases over a small working set of pages
        for (ph = 0; ph < PHASES; ph++) begin
            drain();
            case (ph % 3)
                0:       base = rand48();
                1:       base = LBA_MAX - LBA_W'(POOL_PAGES * 2 * PAGE_SECTORS) + 1'b1;
                default: base = '0;
            endcase
            base[PAGE_SHIFT-1:0] = '0;
            for (i = 0; i < POOL_PAGES; i++) begin
                pool_page[i] = base;
                base = base + LBA_W'(PAGE_SECTORS * $urandom_range(1, 2));
            end
            case (ph)
                1:       cap = LBA_MAX;
                3:       cap = '0;
                5:       cap = rand48();
                default: cap = pool_page[0]
                             + LBA_W'($urandom_range(0, POOL_PAGES * 2 * PAGE_SECTORS));
            endcase
            case (ph)
                1:       mx = 16'd1;
                2:       mx = '1;
                3:       mx = MAX_XFER_RESET;
                4:       mx = '0;
                default: mx = CNT_W'($urandom_range(1, 65535));
            endcase
            write_reg(CFG_CAPACITY, cap);
            write_reg(CFG_MAX_XFER, LBA_W'(mx));

            target = items_sent + RAND_ITEMS / PHASES;
            while (items_sent < target) begin
                pick = $urandom_range(0, 99);
                a = pool_page[$urandom_range(0, POOL_PAGES - 1)]
                  | LBA_W'($urandom_range(0, PAGE_SECTORS - 1));
                if (pick < 60) begin
                    lookup_and_fill(a, pick_count());
                end else if (pick < 75) begin
                    // write ranges: mostly a page or two, sometimes wide
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3, 4, 5: cnt = CNT_W'($urandom_range(1, 48));
                        6, 7:             cnt = CNT_W'($urandom_range(1, 2048));
                        8:                cnt = CNT_W'($urandom);
                        default:          cnt = '0;
                    endcase
                    issue(CMD_INVAL, a - LBA_W'($urandom_range(0, 20)), cnt,
                          rand_way(), 1'($urandom_range(0, 1)));
                end else if (pick < 87) begin
                    issue(CMD_LOOKUP, rand48(), CNT_W'($urandom), rand_way(),
                          1'($urandom_range(0, 1)));
                end else if (pick < 93) begin
                    issue(CMD_FILL, ($urandom_range(0, 1) != 0) ? a : rand48(),
                          CNT_W'($urandom), rand_way(), 1'($urandom_range(0, 1)));
                end else if (pick < 97) begin
                    issue(CMD_NOP, rand48(), CNT_W'($urandom), rand_way(),
                          1'($urandom_range(0, 1)));
                end else begin
                    lookup_and_fill(rand48(), pick_count());
                end
            end
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0)
            $display("sector_page_cache_tags regression: pass");
        else
            $display("sector_page_cache_tags regression: fail");
        $finish;
    end

    // hang guard, well past the slowest legal run
    initial begin
        #20_000_000;
        $display("sector_page_cache_tags regression: fail");
        $finish;
    end

endmodule

FILE: files.f
sv/spct_pkg.sv
sv/spct_match.sv
sv/sector_page_cache_tags.sv
verif/tb_sector_page_cache_tags.sv
